// ----- sv/bdf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdf_pkg
// Shared types and constants of the direct form II biquad: coefficient
// layout, control word of the microcode store and the datapath command.
// ----------------------------------------------------------------------------
package bdf_pkg;

  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 28;

  localparam int COEF_W      = 32;
  localparam int DELAY_W     = 32;
  localparam int COEF_COUNT  = 5;
  localparam int CFG_IDX_W   = 3;
  // A 64-bit product plus two bits of growth for a sum of three.
  localparam int PROD_W      = COEF_W + DELAY_W;
  localparam int ACC_W       = PROD_W + 2;

  localparam int PROG_LEN    = 8;
  localparam int STEP_W      = 3;

  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [DELAY_W-1:0] delay_t;
  typedef logic [STEP_W-1:0]         step_t;

  // Coefficient selector; the values double as configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_sel_t;

  typedef enum logic [1:0] {
    DATA_D1,
    DATA_D2,
    DATA_T
  } data_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_IN,
    COND_OUT
  } cond_t;

  typedef struct packed {
    coef_sel_t coef_sel;
    data_sel_t data_sel;
    acc_op_t   acc_op;
    logic      calc_t;
    cond_t     cond;
    step_t     target;
  } ctrl_word_t;

  typedef struct packed {
    coef_sel_t coef_sel;
    data_sel_t data_sel;
    acc_op_t   acc_op;
    logic      calc_t;
    logic      load;
    logic      retire;
  } dp_cmd_t;

endpackage

// ----- sv/bdf_ucode_rom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdf_ucode_rom
// Read-only control store holding the eight-step filter program.
// ----------------------------------------------------------------------------
module bdf_ucode_rom (
  input  bdf_pkg::step_t      step,
  output bdf_pkg::ctrl_word_t ctrl
);

  // The product register sits between the multiplier and the accumulator, so
  // each accumulate uses the product chosen in the step before.
  localparam bdf_pkg::ctrl_word_t PROGRAM [bdf_pkg::PROG_LEN] = '{
    '{bdf_pkg::COEF_B0, bdf_pkg::DATA_D1, bdf_pkg::ACC_HOLD, 1'b0,
      bdf_pkg::COND_IN,     bdf_pkg::step_t'(1)},
    '{bdf_pkg::COEF_A1, bdf_pkg::DATA_D1, bdf_pkg::ACC_HOLD, 1'b0,
      bdf_pkg::COND_ALWAYS, bdf_pkg::step_t'(2)},
    '{bdf_pkg::COEF_A2, bdf_pkg::DATA_D2, bdf_pkg::ACC_LOAD, 1'b0,
      bdf_pkg::COND_ALWAYS, bdf_pkg::step_t'(3)},
    '{bdf_pkg::COEF_B1, bdf_pkg::DATA_D1, bdf_pkg::ACC_ADD,  1'b0,
      bdf_pkg::COND_ALWAYS, bdf_pkg::step_t'(4)},
    '{bdf_pkg::COEF_B2, bdf_pkg::DATA_D2, bdf_pkg::ACC_LOAD, 1'b1,
      bdf_pkg::COND_ALWAYS, bdf_pkg::step_t'(5)},
    '{bdf_pkg::COEF_B0, bdf_pkg::DATA_T,  bdf_pkg::ACC_ADD,  1'b0,
      bdf_pkg::COND_ALWAYS, bdf_pkg::step_t'(6)},
    '{bdf_pkg::COEF_B0, bdf_pkg::DATA_T,  bdf_pkg::ACC_ADD,  1'b0,
      bdf_pkg::COND_ALWAYS, bdf_pkg::step_t'(7)},
    '{bdf_pkg::COEF_B0, bdf_pkg::DATA_D1, bdf_pkg::ACC_HOLD, 1'b0,
      bdf_pkg::COND_OUT,    bdf_pkg::step_t'(0)}
  };

  assign ctrl = PROGRAM[step];

endmodule

// ----- sv/bdf_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdf_sequencer
// Step counter of the microcode program with its conditional jumps.
// ----------------------------------------------------------------------------
module bdf_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_valid,
  input  logic             out_stall,
  output logic             in_stall,
  output bdf_pkg::dp_cmd_t cmd
);

  bdf_pkg::step_t      step;
  bdf_pkg::ctrl_word_t ctrl;
  logic                go;

  bdf_ucode_rom u_rom (
    .step (step),
    .ctrl (ctrl)
  );

  always_comb begin
    case (ctrl.cond)
      bdf_pkg::COND_ALWAYS: go = 1'b1;
      bdf_pkg::COND_IN:     go = in_valid;
      bdf_pkg::COND_OUT:    go = !out_valid || !out_stall;
      default:              go = 1'b0;
    endcase
  end

  assign in_stall = rst || (ctrl.cond != bdf_pkg::COND_IN);

  always_comb begin
    cmd.coef_sel = ctrl.coef_sel;
    cmd.data_sel = ctrl.data_sel;
    cmd.acc_op   = ctrl.acc_op;
    cmd.calc_t   = ctrl.calc_t;
    cmd.load     = in_valid && !in_stall;
    cmd.retire   = !rst && go && (ctrl.cond == bdf_pkg::COND_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (go) begin
      step <= ctrl.target;
    end
  end

endmodule

// ----- sv/bdf_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdf_datapath
// Shared multiplier, product register, accumulator with rounding and
// saturation, and the two delay registers.
// ----------------------------------------------------------------------------
module bdf_datapath #(
  parameter int SAMPLE_BITS    = bdf_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = bdf_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bdf_pkg::dp_cmd_t              cmd,
  input  bdf_pkg::coef_t                coefs [bdf_pkg::COEF_COUNT],
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          clear_first,
  output logic signed [SAMPLE_BITS-1:0] y
);

  localparam int ACC_W = bdf_pkg::ACC_W;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SMAX =
    {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;
  localparam logic signed [ACC_W-1:0] DMAX =
    {{(ACC_W - bdf_pkg::DELAY_W + 1){1'b0}}, {(bdf_pkg::DELAY_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] DMIN = ~DMAX;

  logic signed [SAMPLE_BITS-1:0]    x;
  bdf_pkg::delay_t                  d1;
  bdf_pkg::delay_t                  d2;
  bdf_pkg::delay_t                  t;
  logic signed [bdf_pkg::PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]          acc;

  bdf_pkg::coef_t                   mul_a;
  bdf_pkg::delay_t                  mul_b;
  logic signed [ACC_W-1:0]          prod_ext;
  logic signed [ACC_W-1:0]          acc_half;
  logic signed [ACC_W-1:0]          rnd;
  logic signed [ACC_W-1:0]          x_ext;
  logic signed [ACC_W-1:0]          t_wide;
  bdf_pkg::delay_t                  t_sat;

  always_comb begin
    mul_a = coefs[cmd.coef_sel];
    case (cmd.data_sel)
      bdf_pkg::DATA_D1: mul_b = d1;
      bdf_pkg::DATA_D2: mul_b = d2;
      bdf_pkg::DATA_T:  mul_b = t;
      default:          mul_b = d1;
    endcase
  end

  // Round half up: add half an LSB of the result, then floor by shifting.
  always_comb begin
    prod_ext = {{(ACC_W - bdf_pkg::PROD_W){prod[bdf_pkg::PROD_W-1]}}, prod};
    acc_half = acc + HALF;
    rnd      = acc_half >>> COEF_FRAC_BITS;
    x_ext    = {{(ACC_W - SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
    t_wide   = x_ext - rnd;
    if (t_wide > DMAX) begin
      t_sat = t_wide[bdf_pkg::DELAY_W-1:0] ^ t_wide[bdf_pkg::DELAY_W-1:0]
              ^ DMAX[bdf_pkg::DELAY_W-1:0];
    end else if (t_wide < DMIN) begin
      t_sat = DMIN[bdf_pkg::DELAY_W-1:0];
    end else begin
      t_sat = t_wide[bdf_pkg::DELAY_W-1:0];
    end
    if (rnd > SMAX) begin
      y = SMAX[SAMPLE_BITS-1:0];
    end else if (rnd < SMIN) begin
      y = SMIN[SAMPLE_BITS-1:0];
    end else begin
      y = rnd[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (cmd.acc_op)
      bdf_pkg::ACC_LOAD: acc <= prod_ext;
      bdf_pkg::ACC_ADD:  acc <= acc + prod_ext;
      default:           acc <= acc;
    endcase
    if (cmd.calc_t) begin
      t <= t_sat;
    end
    if (cmd.load) begin
      x <= sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1 <= '0;
      d2 <= '0;
    end else if (cmd.load && clear_first) begin
      d1 <= '0;
      d2 <= '0;
    end else if (cmd.retire) begin
      d2 <= d1;
      d1 <= t;
    end
  end

endmodule

// ----- sv/biquad_df2_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_df2_filter
// Second-order IIR section in direct form II with fixed-point arithmetic.
// ----------------------------------------------------------------------------
// Samples arrive on the input channel (in_valid, in_stall, sample_in,
// clear_first) and filtered samples leave on the output channel (out_valid,
// out_stall, sample_out). A transaction completes on a rising edge with
// valid high and stall low.
// A small microcode program drives one shared 32 x 32 multiplier: five
// products per sample, an accept step, one step for the last product to
// reach the accumulator and a retire step, eight steps in all. The result is
// written to the output register at the retire step, and no new sample is
// accepted until the program has returned to its accept step.
// The output register lets the next sample be accepted while a result still
// waits; if the receiver stalls longer, the program holds at its retire step
// and the input stays stalled until the output register frees up.
// The user must write coefficients (cfg_we, cfg_index, cfg_data) only while
// the filter is idle, not enforced by the block; indexes above 4 are ignored.
// Reset zeroes both delays, sets b0 to unity and the other coefficients to
// zero, and empties the output register.
// ----------------------------------------------------------------------------
module biquad_df2_filter #(
  parameter int SAMPLE_BITS    = bdf_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = bdf_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in,
  input  logic                                clear_first,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_BITS-1:0]       sample_out,
  input  logic                                cfg_we,
  input  logic [bdf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bdf_pkg::COEF_W-1:0]          cfg_data
);

  localparam bdf_pkg::coef_t B0_RESET = bdf_pkg::coef_t'(1) << COEF_FRAC_BITS;

  bdf_pkg::coef_t                coefs [bdf_pkg::COEF_COUNT];
  bdf_pkg::dp_cmd_t              cmd;
  logic signed [SAMPLE_BITS-1:0] y;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs[bdf_pkg::COEF_B0] <= B0_RESET;
      coefs[bdf_pkg::COEF_B1] <= '0;
      coefs[bdf_pkg::COEF_B2] <= '0;
      coefs[bdf_pkg::COEF_A1] <= '0;
      coefs[bdf_pkg::COEF_A2] <= '0;
    end else if (cfg_we && (cfg_index < bdf_pkg::CFG_IDX_W'(bdf_pkg::COEF_COUNT))) begin
      coefs[cfg_index] <= cfg_data;
    end
  end

  bdf_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  bdf_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .coefs       (coefs),
    .sample_in   (sample_in),
    .clear_first (clear_first),
    .y           (y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.retire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.retire) begin
      sample_out <= y;
    end
  end

  // Only one sample is in flight, so an accepted transaction is always
  // followed by a stalled input.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a sample is in flight");

  // A result must never overwrite one that the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !cmd.retire)
    else $error("result retired over a waiting output");

  a_retire_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.retire |=> out_valid)
    else $error("retired result not presented");

  a_load_not_retire: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !cmd.retire)
    else $error("accept and retire in the same step");

endmodule

// ----- verif/biquad_df2_filter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_df2_filter_tb
// Self-checking testbench for the direct form II biquad. An in-bench fixed-
// point model of the filter predicts every output sample from the accepted
// input transactions and the coefficients written so far. Directed samples
// cover pass-through, the feedback path, clearing, unused register indexes
// and both kinds of saturation. Randomised streams then run under three
// handshake idling profiles.
// ----------------------------------------------------------------------------
module biquad_df2_filter_tb;

  localparam int SAMPLE_W     = bdf_pkg::SAMPLE_BITS_DEF;
  localparam int FRAC_W       = bdf_pkg::COEF_FRAC_BITS_DEF;
  localparam int WIDE_W       = 80;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int REPORT_LIMIT = 10;
  localparam int STREAM_LEN   = 50;

  typedef logic signed [SAMPLE_W-1:0]       sample_t;
  typedef logic signed [WIDE_W-1:0]         wide_t;
  typedef logic [bdf_pkg::CFG_IDX_W-1:0]    cfg_idx_t;

  localparam bdf_pkg::coef_t UNITY    = bdf_pkg::coef_t'(1) <<< FRAC_W;
  localparam bdf_pkg::coef_t COEF_MAX = {1'b0, {(bdf_pkg::COEF_W-1){1'b1}}};
  localparam bdf_pkg::coef_t COEF_MIN = {1'b1, {(bdf_pkg::COEF_W-1){1'b0}}};
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam wide_t   DELAY_HI   = (wide_t'(1) <<< (bdf_pkg::DELAY_W-1)) - 1;
  localparam wide_t   DELAY_LO   = -(wide_t'(1) <<< (bdf_pkg::DELAY_W-1));
  localparam wide_t   OUT_HI     = (wide_t'(1) <<< (SAMPLE_W-1)) - 1;
  localparam wide_t   OUT_LO     = -(wide_t'(1) <<< (SAMPLE_W-1));

  logic                       clk         = 1'b0;
  logic                       rst         = 1'b1;
  logic                       in_valid    = 1'b0;
  logic                       in_stall;
  sample_t                    sample_in   = '0;
  logic                       clear_first = 1'b0;
  logic                       out_valid;
  logic                       out_stall   = 1'b0;
  sample_t                    sample_out;
  logic                       cfg_we      = 1'b0;
  cfg_idx_t                   cfg_index   = '0;
  logic [bdf_pkg::COEF_W-1:0] cfg_data    = '0;

  // Filter state as the bench expects it to be.
  bdf_pkg::coef_t  coefs [bdf_pkg::COEF_COUNT];
  bdf_pkg::delay_t delay_near;
  bdf_pkg::delay_t delay_far;

  sample_t expected_samples [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int checked_count  = 0;
  int sent_count     = 0;
  int coef_sets      = 0;
  int quiet_cycles   = 0;

  biquad_df2_filter uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample_in   (sample_in),
    .clear_first (clear_first),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample_out  (sample_out),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Exact sum of three products, scaled down by the coefficient fraction with
  // round half up.
  function automatic wide_t round_products(input bdf_pkg::coef_t c0, c1, c2,
                                           input bdf_pkg::delay_t d0, d1, d2);
    wide_t cw [3];
    wide_t dw [3];
    wide_t sum;
    cw[0] = c0; cw[1] = c1; cw[2] = c2;
    dw[0] = d0; dw[1] = d1; dw[2] = d2;
    sum = wide_t'(1) <<< (FRAC_W - 1);
    for (int i = 0; i < 3; i++)
      sum = sum + cw[i] * dw[i];
    return sum >>> FRAC_W;
  endfunction

  function automatic sample_t filter_sample(input sample_t x, input logic clear);
    wide_t           xw;
    wide_t           t_full;
    wide_t           y_full;
    bdf_pkg::delay_t t;
    if (clear) begin
      delay_near = '0;
      delay_far  = '0;
    end
    xw = x;
    t_full = xw - round_products(coefs[bdf_pkg::COEF_A1], coefs[bdf_pkg::COEF_A2], '0,
                                 delay_near, delay_far, '0);
    if (t_full > DELAY_HI) t_full = DELAY_HI;
    else if (t_full < DELAY_LO) t_full = DELAY_LO;
    t = t_full[bdf_pkg::DELAY_W-1:0];
    y_full = round_products(coefs[bdf_pkg::COEF_B0], coefs[bdf_pkg::COEF_B1],
                            coefs[bdf_pkg::COEF_B2], t, delay_near, delay_far);
    if (y_full > OUT_HI) y_full = OUT_HI;
    else if (y_full < OUT_LO) y_full = OUT_LO;
    delay_far  = delay_near;
    delay_near = t;
    return y_full[SAMPLE_W-1:0];
  endfunction

  function automatic bdf_pkg::coef_t random_coef(input int shift);
    bdf_pkg::coef_t v;
    v = $urandom;
    return v >>> shift;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with in_valid still high, so back-to-back samples need no extra step.
  task automatic send_sample(input sample_t x, input logic clear);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    sample_in   <= x;
    clear_first <= clear;
    do @(posedge clk); while (in_stall);
    expected_samples.push_back(filter_sample(x, clear));
    sent_count++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0 || in_stall) @(negedge clk);
  endtask

  task automatic write_coef(input cfg_idx_t index, input bdf_pkg::coef_t value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    if (index < bdf_pkg::COEF_COUNT) coefs[index] = value;
    @(negedge clk);
  endtask

  task automatic load_coefs(input bdf_pkg::coef_t b0, b1, b2, a1, a2);
    wait_idle();
    write_coef(bdf_pkg::COEF_B0, b0);
    write_coef(bdf_pkg::COEF_B1, b1);
    write_coef(bdf_pkg::COEF_B2, b2);
    write_coef(bdf_pkg::COEF_A1, a1);
    write_coef(bdf_pkg::COEF_A2, a2);
    cfg_we <= 1'b0;
    @(negedge clk);
    coef_sets++;
  endtask

  // With the reset coefficients the filter is a straight wire.
  task automatic test_passthrough();
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample('0, 1'b0);
    send_sample(sample_t'(1), 1'b1);
    send_sample(sample_t'(-1), 1'b0);
    send_sample(sample_t'('h555555), 1'b0);
    send_sample(sample_t'('haaaaaa), 1'b0);
  endtask

  // A stable resonant section, with writes to the unused indexes mixed in;
  // those must leave every coefficient untouched.
  task automatic test_feedback_path();
    wait_idle();
    for (int idx = bdf_pkg::COEF_COUNT; idx < (1 << bdf_pkg::CFG_IDX_W); idx++)
      write_coef(cfg_idx_t'(idx), $urandom);
    cfg_we <= 1'b0;
    @(negedge clk);
    load_coefs(UNITY >>> 1, UNITY >>> 2, -(UNITY >>> 2),
               -(UNITY - (UNITY >>> 3)), UNITY >>> 2);
    for (int idx = bdf_pkg::COEF_COUNT; idx < (1 << bdf_pkg::CFG_IDX_W); idx++)
      write_coef(cfg_idx_t'(idx), $urandom);
    cfg_we <= 1'b0;
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample('0, 1'b0);
    send_sample('0, 1'b0);
    send_sample(SAMPLE_MIN >>> 1, 1'b1);
    send_sample('0, 1'b0);
    send_sample('0, 1'b0);
  endtask

  // Coefficients at their limits drive the delays into saturation within a
  // few samples and the output at once; a clear then restarts from empty.
  task automatic test_saturation();
    load_coefs(COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN);
    repeat (6) send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    repeat (3) send_sample(SAMPLE_MIN, 1'b0);
  endtask

  task automatic test_random_stream(input int send_pct, input int recv_pct);
    sample_t x;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int shape = 0; shape < 3; shape++) begin
      case (shape)
        0: load_coefs(random_coef(3), random_coef(3), random_coef(3),
                      random_coef(2), random_coef(3));
        1: load_coefs(random_coef(0), random_coef(0), random_coef(0),
                      random_coef(0), random_coef(0));
        default: load_coefs(random_coef(6), random_coef(6), random_coef(6),
                            random_coef(2), random_coef(3));
      endcase
      for (int n = 0; n < STREAM_LEN; n++) begin
        case ($urandom_range(7))
          0: x = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
          1, 2: begin
            x = sample_t'($urandom);
            x = x >>> 12;
          end
          default: x = sample_t'($urandom);
        endcase
        send_sample(x, $urandom_range(19) == 0);
      end
    end
  endtask

  always @(negedge clk)
    out_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin : check_output
    sample_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected output transaction: sample_out=%0d", sample_out);
      end else begin
        want = expected_samples.pop_front();
        checked_count++;
        if (sample_out !== want) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("sample_out mismatch on output %0d: expected %0d, got %0d",
                     checked_count, want, sample_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (coefs[i]) coefs[i] = '0;
    coefs[bdf_pkg::COEF_B0] = UNITY;
    delay_near = '0;
    delay_far  = '0;
    send_idle_pct  = 34;
    recv_stall_pct = 86;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_passthrough();
    test_feedback_path();
    test_saturation();
    test_random_stream(34, 86);
    test_random_stream(86, 34);
    test_random_stream(0, 0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    fail_count += expected_samples.size();

    $display("run covered %0d samples over %0d coefficient sets, %0d outputs checked",
             sent_count, coef_sets, checked_count);
    $display("idling profiles: sender-light, receiver-light and none; %0d failures",
             fail_count);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
